### sv/sfsc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the SYN flood source counter.
// No dependencies; every other file of the block but sfsc_ram imports this package.
package sfsc_pkg;

   // Widths fixed by the packet fields and the configuration register
   localparam int IP_W           = 32;
   localparam int THRESHOLD_W    = 15;
   localparam int SOURCE_COUNT_W = 16;

   // Reset value of the SYN threshold register
   localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 15'd100;

   // Queue between the classifying front and the table back end
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;

   // What a packet does to the counter of its source
   typedef enum logic [1:0] {
      OP_PASS,
      OP_SYN,
      OP_ACK
   } op_type;

endpackage

### sv/syn_flood_source_counter_top.sv
`timescale 1ns / 1ps
// Top level of the SYN flood source counter: threshold register, front end
// and back end. Uses sfsc_pkg, sfsc_front, sfsc_back (and through it sfsc_ram).
//
//   channel   handshake          word
//   -------   ----------------   -----------------------------------------
//   request   start & !busy      req_src_ip, req_syn_flag, req_ack_flag
//   response  rsp_strobe         rsp_drop, rsp_source_count,
//                                rsp_slot_replaced (one cycle each)
//   config    csr_wr_en          csr_wr_data (syn threshold, no read-back)
//
// The back end reads a word's table slot in ST_IDLE, then updates and writes
// it back in ST_EXEC; the registered table read sets this, since a word's
// write must land before the next word's read, so no new word is taken before
// the last is written back. Accepted words pass the s1 register and the queue;
// rsp_strobe is registered from ST_EXEC. After reset busy stays high while the
// table is swept clear, one entry a cycle. The front queue holds up to four
// words, so the requester sees busy only once it runs ahead of the back end.
// The receiver cannot stall: every response shows for exactly one cycle.
module syn_flood_source_counter_top #(
   parameter int TABLE_ENTRIES = 1024,
   parameter int COUNT_BITS    = 16
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       start,
   output logic                                       busy,
   input  logic [sfsc_pkg::IP_W-1:0]                  req_src_ip,
   input  logic                                       req_syn_flag,
   input  logic                                       req_ack_flag,
   output logic                                       rsp_strobe,
   output logic                                       rsp_drop,
   output logic signed [sfsc_pkg::SOURCE_COUNT_W-1:0] rsp_source_count,
   output logic                                       rsp_slot_replaced,
   input  logic                                       csr_wr_en,
   input  logic [sfsc_pkg::THRESHOLD_W-1:0]           csr_wr_data
);
   import sfsc_pkg::*;

   localparam int SLOT_W = $clog2(TABLE_ENTRIES);

   logic [THRESHOLD_W-1:0] threshold_ff, threshold_in;
   logic                   clearing;
   logic                   q_valid;
   logic [IP_W-1:0]        q_ip;
   op_type                 q_op;
   logic [SLOT_W-1:0]      q_slot;
   logic                   q_pop;

   // Take a new threshold on every write; hold it otherwise
   assign threshold_in = csr_wr_en ? csr_wr_data : threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
      end else begin
         threshold_ff <= threshold_in;
      end
   end

   // Classify, fold the address to a slot, queue
   sfsc_front #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .src_ip   (req_src_ip),
      .syn_flag (req_syn_flag),
      .ack_flag (req_ack_flag),
      .clearing (clearing),
      .q_valid  (q_valid),
      .q_ip     (q_ip),
      .q_op     (q_op),
      .q_slot   (q_slot),
      .q_pop    (q_pop)
   );

   // Look up, saturate the counter, write back, report
   sfsc_back #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .COUNT_BITS    (COUNT_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .threshold         (threshold_ff),
      .q_valid           (q_valid),
      .q_ip              (q_ip),
      .q_op              (q_op),
      .q_slot            (q_slot),
      .q_pop             (q_pop),
      .clearing          (clearing),
      .rsp_strobe        (rsp_strobe),
      .rsp_drop          (rsp_drop),
      .rsp_source_count  (rsp_source_count),
      .rsp_slot_replaced (rsp_slot_replaced)
   );

endmodule

### sv/sfsc_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module sfsc_ram #(
   parameter int WIDTH = 49,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/sfsc_front.sv
`timescale 1ns / 1ps
// Front end: accepts packet words, classifies them and folds the source
// address into a table slot, then queues them for the back end. Uses sfsc_pkg.
module sfsc_front #(
   parameter int TABLE_ENTRIES = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [sfsc_pkg::IP_W-1:0]        src_ip,
   input  logic                             syn_flag,
   input  logic                             ack_flag,
   input  logic                             clearing,
   output logic                             q_valid,
   output logic [sfsc_pkg::IP_W-1:0]        q_ip,
   output sfsc_pkg::op_type                 q_op,
   output logic [$clog2(TABLE_ENTRIES)-1:0] q_slot,
   input  logic                             q_pop
);
   import sfsc_pkg::*;

   localparam int SLOT_W = $clog2(TABLE_ENTRIES);
   localparam longint unsigned RECIP = (64'd1 << 32) / TABLE_ENTRIES;
   localparam int RECIP_W = $clog2(RECIP + 1);
   localparam int PROD_W  = 16 + RECIP_W;
   localparam int QUOT_W  = PROD_W - 32;
   localparam logic [RECIP_W-1:0] RECIP_K = RECIP_W'(RECIP);
   localparam logic [31:0] ENTRIES_K = 32'(TABLE_ENTRIES);

   logic                   accept;
   logic [15:0]            fold;
   logic [PROD_W-1:0]      quot_prod;
   op_type                 op_class;

   logic                   s1_valid_ff;
   logic [IP_W-1:0]        s1_ip_ff;
   op_type                 s1_op_ff;
   logic [15:0]            s1_fold_ff;
   logic [QUOT_W-1:0]      s1_quot_ff;

   logic [31:0]            slot_prod;
   logic [31:0]            rem_raw;
   logic [31:0]            rem_fix;
   logic [SLOT_W-1:0]      slot;

   logic [IP_W-1:0]        q_ip_ff   [QUEUE_DEPTH];
   op_type                 q_op_ff   [QUEUE_DEPTH];
   logic [SLOT_W-1:0]      q_slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;

   // Hold off new words while the table clears or no queue space is left
   // for the word in flight plus a new one
   assign busy   = clearing
                 || ((count_ff + {{QUEUE_PTR_W{1'b0}}, s1_valid_ff})
                     >= (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
   assign accept = start && !busy;

   assign fold = src_ip[31:16] ^ src_ip[15:0];
   // Quotient estimate by reciprocal; low by at most one
   assign quot_prod = PROD_W'(fold) * PROD_W'(RECIP_K);

   always_comb begin
      if (syn_flag) begin
         op_class = OP_SYN;
      end else if (ack_flag) begin
         op_class = OP_ACK;
      end else begin
         op_class = OP_PASS;
      end
   end

   // Remainder with one corrective subtract
   assign slot_prod = 32'(s1_quot_ff) * ENTRIES_K;
   assign rem_raw   = 32'(s1_fold_ff) - slot_prod;
   assign rem_fix   = (rem_raw >= ENTRIES_K) ? rem_raw - ENTRIES_K : rem_raw;
   assign slot      = rem_fix[SLOT_W-1:0];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (s1_valid_ff) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      case ({s1_valid_ff, q_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         s1_valid_ff <= accept;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ip_ff   <= src_ip;
         s1_op_ff   <= op_class;
         s1_fold_ff <= fold;
         s1_quot_ff <= quot_prod[PROD_W-1:32];
      end
      if (s1_valid_ff) begin
         q_ip_ff[wr_ptr_ff]   <= s1_ip_ff;
         q_op_ff[wr_ptr_ff]   <= s1_op_ff;
         q_slot_ff[wr_ptr_ff] <= slot;
      end
   end

   assign q_valid = (count_ff != '0);
   assign q_ip    = q_ip_ff[rd_ptr_ff];
   assign q_op    = q_op_ff[rd_ptr_ff];
   assign q_slot  = q_slot_ff[rd_ptr_ff];

endmodule

### sv/sfsc_back.sv
`timescale 1ns / 1ps
// Back end: clears the source table after reset, then looks up, updates and
// writes back one queued packet at a time. Uses sfsc_pkg and sfsc_ram.
module sfsc_back #(
   parameter int TABLE_ENTRIES = 1024,
   parameter int COUNT_BITS    = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [sfsc_pkg::THRESHOLD_W-1:0]    threshold,
   input  logic                                q_valid,
   input  logic [sfsc_pkg::IP_W-1:0]           q_ip,
   input  sfsc_pkg::op_type                    q_op,
   input  logic [$clog2(TABLE_ENTRIES)-1:0]    q_slot,
   output logic                                q_pop,
   output logic                                clearing,
   output logic                                rsp_strobe,
   output logic                                rsp_drop,
   output logic signed [sfsc_pkg::SOURCE_COUNT_W-1:0] rsp_source_count,
   output logic                                rsp_slot_replaced
);
   import sfsc_pkg::*;

   localparam int SLOT_W = $clog2(TABLE_ENTRIES);
   localparam int WORD_W = 1 + IP_W + COUNT_BITS;
   localparam logic signed [COUNT_BITS-1:0] CNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
   localparam logic signed [COUNT_BITS-1:0] CNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_ENTRIES - 1);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type                     state_ff, state_in;
   logic [SLOT_W-1:0]             clear_ptr_ff, clear_ptr_in;
   logic [IP_W-1:0]               cur_ip_ff;
   op_type                        cur_op_ff;
   logic [SLOT_W-1:0]             cur_slot_ff;
   logic                          rsp_strobe_ff, rsp_strobe_in;
   logic                          rsp_drop_ff, rsp_drop_in;
   logic signed [SOURCE_COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic                          rsp_replaced_ff, rsp_replaced_in;

   logic                          wr_en;
   logic [SLOT_W-1:0]             wr_addr;
   logic [WORD_W-1:0]             wr_data;
   logic [WORD_W-1:0]             rd_data;
   logic                          rd_en;

   logic                          ent_valid;
   logic [IP_W-1:0]               ent_ip;
   logic signed [COUNT_BITS-1:0]  ent_count;
   logic                          hit;
   logic signed [COUNT_BITS-1:0]  base_count;
   logic signed [COUNT_BITS-1:0]  new_count;
   logic                          drop_now;

   sfsc_ram #(
      .WIDTH (WORD_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (q_slot),
      .rd_data (rd_data)
   );

   assign ent_valid = rd_data[WORD_W-1];
   assign ent_ip    = rd_data[WORD_W-2 -: IP_W];
   assign ent_count = signed'(rd_data[COUNT_BITS-1:0]);
   assign hit       = ent_valid && (ent_ip == cur_ip_ff);
   // Claim the slot with count zero on a miss
   assign base_count = hit ? ent_count : '0;

   always_comb begin
      new_count = base_count;
      drop_now  = 1'b0;
      case (cur_op_ff)
         OP_SYN: begin
            if (base_count != CNT_MAX) begin
               new_count = base_count + 1'b1;
            end
            drop_now = (33'(new_count) >= signed'(33'(threshold)));
         end
         OP_ACK: begin
            if (base_count != CNT_MIN) begin
               new_count = base_count - 1'b1;
            end
         end
         default: new_count = base_count;
      endcase
   end

   assign rd_en = (state_ff == ST_IDLE) && q_valid;
   assign q_pop = rd_en;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cur_slot_ff;
      wr_data = {1'b1, cur_ip_ff, new_count};
      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clear_ptr_ff;
            wr_data = '0;
         end
         ST_EXEC: wr_en = 1'b1;
         default: wr_en = 1'b0;
      endcase
   end

   always_comb begin
      state_in        = state_ff;
      clear_ptr_in    = clear_ptr_ff;
      rsp_strobe_in   = 1'b0;
      rsp_drop_in     = rsp_drop_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_replaced_in = rsp_replaced_ff;
      case (state_ff)
         ST_CLEAR: begin
            clear_ptr_in = clear_ptr_ff + 1'b1;
            if (clear_ptr_ff == LAST_SLOT) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            rsp_strobe_in   = 1'b1;
            rsp_drop_in     = drop_now;
            rsp_count_in    = SOURCE_COUNT_W'(new_count);
            rsp_replaced_in = ent_valid && !hit;
            state_in        = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_ptr_ff  <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_ptr_ff  <= clear_ptr_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      rsp_drop_ff     <= rsp_drop_in;
      rsp_count_ff    <= rsp_count_in;
      rsp_replaced_ff <= rsp_replaced_in;
      if (rd_en) begin
         cur_ip_ff   <= q_ip;
         cur_op_ff   <= q_op;
         cur_slot_ff <= q_slot;
      end
   end

   assign clearing          = (state_ff == ST_CLEAR);
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_drop          = rsp_drop_ff;
   assign rsp_source_count  = rsp_count_ff;
   assign rsp_slot_replaced = rsp_replaced_ff;

endmodule

### tb/syn_flood_source_counter_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for syn_flood_source_counter_top: table-driven and
// random packet words, checked against a per-source counter table of its own.
// Depends on sfsc_pkg and on the block's RTL, nothing else.
module syn_flood_source_counter_top_tb;
   import sfsc_pkg::*;

   // Block configuration under test: keep it at the top level's defaults
   localparam int TABLE_N  = 1024;
   localparam int CNT_BITS = 16;
   localparam int CNT_MAX  = 2 ** (CNT_BITS - 1) - 1;
   localparam int CNT_MIN  = -CNT_MAX - 1;

   // What one response word carries
   typedef struct packed {
      logic                      drop;
      logic [SOURCE_COUNT_W-1:0] count;
      logic                      replaced;
   } pkt_verdict_type;

   // One row of the directed table; 'pinned' rows carry a hand-written verdict
   typedef struct packed {
      logic [IP_W-1:0]           ip;
      logic                      syn;
      logic                      ack;
      logic                      pinned;
      logic                      drop;
      logic [SOURCE_COUNT_W-1:0] count;
      logic                      replaced;
   } stim_row_type;

   // Directed rows, threshold at its reset value and the table freshly swept.
   // Slot 0 is shared by 0, all ones, 0x400 and 0x00010001; slot 1023 by
   // 0x3FF, 0xFFFFFC00 and both 0xA5/0x5A patterns.
   localparam int N_ROWS = 18;
   localparam stim_row_type DIRECTED [N_ROWS] = '{
      '{32'h0000_0000, 1'b0, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0}, // pass on a fresh slot
      '{32'h0000_0000, 1'b1, 1'b0, 1'b1, 1'b0, 16'h0001, 1'b0}, // SYN adds one
      '{32'h0000_0000, 1'b0, 1'b1, 1'b1, 1'b0, 16'h0000, 1'b0}, // ACK takes one
      '{32'h0000_0000, 1'b0, 1'b1, 1'b1, 1'b0, 16'hFFFF, 1'b0}, // goes negative
      '{32'h0000_0000, 1'b1, 1'b1, 1'b1, 1'b0, 16'h0000, 1'b0}, // SYN and ACK is a SYN
      '{32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1, 1'b0, 16'h0001, 1'b1}, // evicts address zero
      '{32'h0000_0000, 1'b0, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b1}, // pass still claims
      '{32'h0000_0400, 1'b1, 1'b0, 1'b1, 1'b0, 16'h0001, 1'b1}, // index wraps modulo
      '{32'h0001_0001, 1'b0, 1'b1, 1'b1, 1'b0, 16'hFFFF, 1'b1},
      '{32'h0000_03FF, 1'b1, 1'b0, 1'b1, 1'b0, 16'h0001, 1'b0}, // top slot
      '{32'hFFFF_FC00, 1'b0, 1'b1, 1'b1, 1'b0, 16'hFFFF, 1'b1},
      '{32'hFFFF_FC00, 1'b0, 1'b1, 1'b1, 1'b0, 16'hFFFE, 1'b0}, // hit, back to back
      '{32'hA5A5_5A5A, 1'b1, 1'b0, 1'b1, 1'b0, 16'h0001, 1'b1},
      '{32'h1234_5678, 1'b0, 1'b1, 1'b1, 1'b0, 16'hFFFF, 1'b0},
      '{32'h1234_5678, 1'b1, 1'b1, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{32'h5A5A_A5A5, 1'b1, 1'b1, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{32'h8000_0001, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{32'h7FFF_FFFE, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0}
   };

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             start;
   logic                             busy;
   logic [IP_W-1:0]                  req_src_ip;
   logic                             req_syn_flag;
   logic                             req_ack_flag;
   logic                             rsp_strobe;
   logic                             rsp_drop;
   logic signed [SOURCE_COUNT_W-1:0] rsp_source_count;
   logic                             rsp_slot_replaced;
   logic                             csr_wr_en;
   logic [THRESHOLD_W-1:0]           csr_wr_data;

   // Our own copy of the source table and the threshold register
   bit                     src_valid [TABLE_N];
   logic [IP_W-1:0]        src_owner [TABLE_N];
   int                     src_count [TABLE_N];
   logic [THRESHOLD_W-1:0] syn_limit = THRESHOLD_RESET;

   pkt_verdict_type pending_verdicts [$];  // verdicts still owed by the block
   logic [IP_W-1:0] hot_ips [16];          // sources that recur in random traffic
   int              idle_pct;              // chance in a hundred of a sender gap
   int              errors       = 0;
   int              words_sent   = 0;
   int              words_seen   = 0;
   int              drops_seen   = 0;
   int              evicts_seen  = 0;
   int              limits_tried = 0;

   syn_flood_source_counter_top #(
      .TABLE_ENTRIES(TABLE_N),
      .COUNT_BITS   (CNT_BITS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_src_ip       (req_src_ip),
      .req_syn_flag     (req_syn_flag),
      .req_ack_flag     (req_ack_flag),
      .rsp_strobe       (rsp_strobe),
      .rsp_drop         (rsp_drop),
      .rsp_source_count (rsp_source_count),
      .rsp_slot_replaced(rsp_slot_replaced),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always #5 clock = ~clock;

   // Apply one packet to the table copy and return the verdict the block owes.
   // The slot is claimed whatever the flags; SYN wins over ACK.
   function automatic pkt_verdict_type classify_packet(logic [IP_W-1:0] ip,
                                                        logic syn, logic ack);
      int              slot;
      int              cnt;
      op_type          op;
      pkt_verdict_type v;
      slot       = int'(ip[31:16] ^ ip[15:0]) % TABLE_N;
      op         = syn ? OP_SYN : (ack ? OP_ACK : OP_PASS);
      v.drop     = 1'b0;
      v.replaced = 1'b0;
      if (!src_valid[slot] || src_owner[slot] != ip) begin
         v.replaced      = src_valid[slot];
         src_valid[slot] = 1'b1;
         src_owner[slot] = ip;
         src_count[slot] = 0;
      end
      cnt = src_count[slot];
      case (op)
         OP_SYN: begin
            if (cnt < CNT_MAX) cnt = cnt + 1;
            v.drop = (cnt >= int'(syn_limit));
         end
         OP_ACK: begin
            if (cnt > CNT_MIN) cnt = cnt - 1;
         end
         default: ;
      endcase
      src_count[slot] = cnt;
      v.count         = cnt[SOURCE_COUNT_W-1:0];
      return v;
   endfunction

   // Another address that folds onto the same slot as ip
   function automatic logic [IP_W-1:0] slot_rival(logic [IP_W-1:0] ip, logic [15:0] k);
      return ip ^ {k, k};
   endfunction

   // Offer one word, holding start high until the block takes it. Gaps are
   // drawn cycle by cycle, with junk on the fields while start is low.
   task automatic send_word(logic [IP_W-1:0] ip, logic syn, logic ack,
                            bit pinned = 1'b0, pkt_verdict_type pinned_v = '0);
      pkt_verdict_type v;
      while ($urandom_range(0, 99) < idle_pct) begin
         start        <= 1'b0;
         req_src_ip   <= $urandom;
         req_syn_flag <= 1'($urandom_range(0, 1));
         req_ack_flag <= 1'($urandom_range(0, 1));
         @(posedge clock);
      end
      start        <= 1'b1;
      req_src_ip   <= ip;
      req_syn_flag <= syn;
      req_ack_flag <= ack;
      do @(posedge clock); while (busy);
      // Taken at this edge: advance the table copy and queue the verdict
      v = classify_packet(ip, syn, ack);
      if (pinned) v = pinned_v;
      pending_verdicts.push_back(v);
      words_sent++;
   endtask

   task automatic repeat_word(logic [IP_W-1:0] ip, logic syn, logic ack, int n);
      repeat (n) send_word(ip, syn, ack);
   endtask

   // Drop start and hold off until every owed verdict is in, plus the pipe depth
   task automatic drain_words;
      start <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Write the threshold; only called with the block drained
   task automatic set_syn_limit(logic [THRESHOLD_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      syn_limit    = value;
      limits_tried++;
   endtask

   // Mostly recurring sources so counts climb past the threshold, with bursts
   // on one source (back-to-back slot hits), slot rivals to force evictions
   // and a share of fully random words.
   task automatic random_traffic(int n);
      int              done;
      int              pick;
      int              len;
      int              fsel;
      logic [IP_W-1:0] ip;
      logic            syn;
      logic            ack;
      done = 0;
      while (done < n) begin
         pick = $urandom_range(0, 99);
         fsel = $urandom_range(0, 9);
         syn  = (fsel <= 4) || (fsel == 8);
         ack  = (fsel >= 5) && (fsel <= 8);
         if (pick < 15) begin
            ip  = hot_ips[$urandom_range(0, 15)];
            len = $urandom_range(2, 8);
            repeat_word(ip, syn, ack, len);
            done += len;
         end else begin
            if (pick < 70) begin
               ip = hot_ips[$urandom_range(0, 15)];
            end else if (pick < 85) begin
               ip = slot_rival(hot_ips[$urandom_range(0, 15)],
                               16'($urandom_range(1, 65535)));
            end else begin
               ip  = $urandom;
               syn = 1'($urandom_range(0, 1));
               ack = 1'($urandom_range(0, 1));
            end
            send_word(ip, syn, ack);
            done++;
         end
      end
   endtask

   // Response checker: the block cannot be stalled, so take every strobe
   always @(posedge clock) begin
      pkt_verdict_type want;
      if (!reset && rsp_strobe) begin
         words_seen++;
         if (rsp_drop)          drops_seen++;
         if (rsp_slot_replaced) evicts_seen++;
         if (pending_verdicts.size() == 0) begin
            errors++;
            $error("response word with no verdict pending");
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_drop !== want.drop) begin
               errors++;
               $error("rsp_drop: expected %0d, got %0d", want.drop, rsp_drop);
            end
            if (rsp_source_count !== want.count) begin
               errors++;
               $error("rsp_source_count: expected %0d, got %0d",
                      $signed(want.count), rsp_source_count);
            end
            if (rsp_slot_replaced !== want.replaced) begin
               errors++;
               $error("rsp_slot_replaced: expected %0d, got %0d",
                      want.replaced, rsp_slot_replaced);
            end
         end
      end
   end

   // Hard stop well beyond the slowest correct run
   initial begin
      #10_000_000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      pkt_verdict_type pv;
      logic [IP_W-1:0] lone_ip;
      start        <= 1'b0;
      req_src_ip   <= '0;
      req_syn_flag <= 1'b0;
      req_ack_flag <= 1'b0;
      csr_wr_en    <= 1'b0;
      csr_wr_data  <= '0;
      reset        <= 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed table at the reset threshold; busy covers the table sweep
      idle_pct = 27;
      foreach (DIRECTED[i]) begin
         pv = '{DIRECTED[i].drop, DIRECTED[i].count, DIRECTED[i].replaced};
         send_word(DIRECTED[i].ip, DIRECTED[i].syn, DIRECTED[i].ack,
                   DIRECTED[i].pinned, pv);
      end
      // A hundred SYNs from one source: the hundredth is the first dropped
      repeat_word(32'h0A00_0001, 1'b1, 1'b0, 100);

      // Recurring sources; a few pairs share a slot, extremes among them
      foreach (hot_ips[i]) hot_ips[i] = $urandom;
      hot_ips[0] = 32'h0000_0000;
      hot_ips[1] = 32'hFFFF_FFFF;
      for (int i = 8; i < 12; i++)
         hot_ips[i] = slot_rival(hot_ips[i - 8], 16'($urandom_range(1, 65535)));

      // Sender idles often at a low threshold
      drain_words();
      set_syn_limit(15'd3);
      random_traffic(600);

      // Sender idles most of the time; threshold of one
      drain_words();
      idle_pct = 73;
      set_syn_limit(15'd1);
      random_traffic(400);

      // No idling from here on. Zero threshold: any SYN landing on zero or
      // above is dropped
      drain_words();
      idle_pct = 0;
      set_syn_limit(15'd0);
      random_traffic(300);

      drain_words();
      set_syn_limit(15'($urandom_range(2, 40)));
      random_traffic(400);

      // Top threshold: one source climbs with no drop, steps down and back,
      // then a rival claims its slot and goes negative
      drain_words();
      set_syn_limit(15'h7FFF);
      lone_ip = 32'hC0A8_0101;
      repeat_word(lone_ip, 1'b1, 1'b0, 20);
      repeat_word(lone_ip, 1'b0, 1'b1, 5);
      repeat_word(lone_ip, 1'b1, 1'b1, 4);
      lone_ip = slot_rival(lone_ip, 16'h0001);
      repeat_word(lone_ip, 1'b0, 1'b1, 5);
      repeat_word(lone_ip, 1'b1, 1'b0, 2);

      drain_words();
      $display("Sent %0d packet words over %0d threshold settings, zero and both extremes",
               words_sent, limits_tried + 1);
      $display("Checked %0d responses: %0d drops, %0d evictions, bursts on shared slots",
               words_seen, drops_seen, evicts_seen);
      if (errors == 0 && pending_verdicts.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
